### design/text_console_writer_core_defines.svh
// ----------------------------------------------------------------------------
// Text console writer: assertion macros
// Shared macros for the concurrent checks on the console writer ports.
// ----------------------------------------------------------------------------
`ifndef TEXT_CONSOLE_WRITER_CORE_DEFINES_SVH
`define TEXT_CONSOLE_WRITER_CORE_DEFINES_SVH

// Same-cycle implication, checked only while out of reset.
`define TCW_ASSERT_NOW(label, clk, rstn, pre, post) \
  label: assert property (@(posedge clk) disable iff (!(rstn)) (pre) |-> (post)) \
    else $error("text console writer: same-cycle check failed");

// Next-cycle implication, checked only while out of reset.
`define TCW_ASSERT_NEXT(label, clk, rstn, pre, post) \
  label: assert property (@(posedge clk) disable iff (!(rstn)) (pre) |=> (post)) \
    else $error("text console writer: next-cycle check failed");

`endif

### design/tcw_pkg.sv
// ----------------------------------------------------------------------------
// Text console writer package
// Field widths, character codes, command codes and controller interface types.
// ----------------------------------------------------------------------------
package tcw_pkg;

  localparam int DEF_COLUMNS = 80;
  localparam int DEF_ROWS    = 25;

  localparam int CMD_W     = 2;
  localparam int CHAR_W    = 8;
  localparam int ATTR_W    = 8;
  localparam int IDX_W     = 11;
  localparam int OUT_ROW_W = 5;
  localparam int OUT_COL_W = 7;
  localparam int POS_W     = 11;
  localparam int CELL_W    = 16;

  localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'd10;
  localparam logic [CHAR_W-1:0] CH_RETURN    = 8'd13;
  localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'd8;
  localparam logic [CHAR_W-1:0] CH_BLANK     = 8'd32;
  localparam logic [ATTR_W-1:0] RESET_ATTR   = 8'h0F;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUT   = 2'd0,
    CMD_CLEAR = 2'd1,
    CMD_READ  = 2'd2
  } command_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;     // latch the incoming item
    logic ptr_clr;    // restart the sweep pointer
    logic put;        // perform a put-character step
    logic copy;       // scroll copy: read one row below, advance
    logic fill;       // write a blank at the sweep pointer, advance
    logic fill_init;  // blank with the reset attribute
    logic home;       // cursor to row 0, column 0
    logic load_out;   // move the result into the output register
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic need_scroll;
    logic copy_end;
    logic fill_end;
    logic out_free;
  } dp_sts_t;

endpackage

### design/tcw_ctrl.sv
// ----------------------------------------------------------------------------
// Text console writer controller
// Sequences put, clear, read, scroll and the post-reset screen clearing pass.
// ----------------------------------------------------------------------------
module tcw_ctrl import tcw_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic [CMD_W-1:0] command_i,
  output logic             in_stall_o,
  input  dp_sts_t          sts_i,
  output ctrl_cmd_t        cmd_o
);

  typedef enum logic [8:0] {
    S_INIT  = 9'b000000001,
    S_IDLE  = 9'b000000010,
    S_PUT   = 9'b000000100,
    S_READ  = 9'b000001000,
    S_CLEAR = 9'b000010000,
    S_COPY  = 9'b000100000,
    S_DRAIN = 9'b001000000,
    S_SFILL = 9'b010000000,
    S_DONE  = 9'b100000000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_INIT: begin
        cmd_o.fill      = 1'b1;
        cmd_o.fill_init = 1'b1;
        if (sts_i.fill_end) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.accept  = 1'b1;
          cmd_o.ptr_clr = 1'b1;
          case (command_i)
            CMD_PUT:   state_d = S_PUT;
            CMD_CLEAR: state_d = S_CLEAR;
            CMD_READ:  state_d = S_READ;
            default:   state_d = S_DONE;
          endcase
        end
      end
      S_PUT: begin
        cmd_o.put     = 1'b1;
        cmd_o.ptr_clr = 1'b1;
        state_d = sts_i.need_scroll ? S_COPY : S_DONE;
      end
      S_READ: begin
        state_d = S_DONE;
      end
      S_CLEAR: begin
        cmd_o.fill = 1'b1;
        if (sts_i.fill_end) begin
          cmd_o.home = 1'b1;
          state_d    = S_DONE;
        end
      end
      S_COPY: begin
        cmd_o.copy = 1'b1;
        if (sts_i.copy_end) begin
          state_d = S_DRAIN;
        end
      end
      // The last copied cell is written here, before the bottom row is blanked.
      S_DRAIN: begin
        state_d = S_SFILL;
      end
      S_SFILL: begin
        cmd_o.fill = 1'b1;
        if (sts_i.fill_end) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (sts_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign in_stall_o = (state_q != S_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_INIT;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

### design/tcw_dp.sv
// ----------------------------------------------------------------------------
// Text console writer datapath
// Screen store, cursor, attribute register, sweep pointer and result register.
// ----------------------------------------------------------------------------
module tcw_dp import tcw_pkg::*; #(
  parameter int COLUMNS = DEF_COLUMNS,
  parameter int ROWS    = DEF_ROWS
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [ATTR_W-1:0]    cfg_wdata_i,
  input  logic [CMD_W-1:0]     command_i,
  input  logic [CHAR_W-1:0]    char_code_i,
  input  logic [IDX_W-1:0]     cell_index_i,
  input  ctrl_cmd_t            cmd_i,
  output dp_sts_t              sts_o,
  input  logic                 out_stall_i,
  output logic                 out_valid_o,
  output logic [OUT_ROW_W-1:0] cursor_row_o,
  output logic [OUT_COL_W-1:0] cursor_col_o,
  output logic [POS_W-1:0]     cursor_position_o,
  output logic [CELL_W-1:0]    cell_data_o,
  output logic                 scrolled_o
);

  localparam int CELL_COUNT = ROWS * COLUMNS;
  localparam int COPY_COUNT = (ROWS - 1) * COLUMNS;
  localparam int ADDR_W     = $clog2(CELL_COUNT);
  localparam int ROW_W      = $clog2(ROWS);
  localparam int COL_W      = $clog2(COLUMNS);

  localparam logic [ADDR_W-1:0] COPY_LAST = ADDR_W'(COPY_COUNT - 1);
  localparam logic [ADDR_W-1:0] CELL_LAST = ADDR_W'(CELL_COUNT - 1);
  localparam logic [ADDR_W-1:0] ROW_STEP  = ADDR_W'(COLUMNS);
  localparam logic [ROW_W-1:0]  ROW_LAST  = ROW_W'(ROWS - 1);
  localparam logic [COL_W-1:0]  COL_LAST  = COL_W'(COLUMNS - 1);

  logic [CELL_W-1:0] screen_q [CELL_COUNT];
  logic [CELL_W-1:0] rdata_q;

  logic [ATTR_W-1:0] attr_q;
  logic [ROW_W-1:0]  row_q, row_d;
  logic [COL_W-1:0]  col_q, col_d;
  logic [ADDR_W-1:0] ptr_q;
  logic [ADDR_W-1:0] wptr_q;
  logic              pend_q;
  logic [CMD_W-1:0]  item_cmd_q;
  logic [CHAR_W-1:0] item_char_q;
  logic [ADDR_W-1:0] item_addr_q;
  logic              item_in_range_q;
  logic              scrolled_q;

  logic                 out_valid_q;
  logic [OUT_ROW_W-1:0] out_row_q;
  logic [OUT_COL_W-1:0] out_col_q;
  logic [POS_W-1:0]     out_pos_q;
  logic [CELL_W-1:0]    out_data_q;
  logic                 out_scrolled_q;

  logic              in_range;
  logic              put_we;
  logic [COL_W-1:0]  put_col;
  logic [CHAR_W-1:0] put_char;
  logic              put_scroll;
  logic [ROW_W-1:0]  row_adv;
  logic [ADDR_W-1:0] put_addr;
  logic [ADDR_W-1:0] cursor_addr;
  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  logic [CELL_W-1:0] mem_wdata;
  logic [ADDR_W-1:0] mem_raddr;
  logic [ATTR_W-1:0] fill_attr;

  assign in_range = ({21'd0, cell_index_i} < 32'(CELL_COUNT));
  assign row_adv  = (row_q == ROW_LAST) ? row_q : row_q + ROW_W'(1);

  // Put-character step: new cursor and the single cell write, if any, that it causes.
  always_comb begin
    row_d      = row_q;
    col_d      = col_q;
    put_we     = 1'b0;
    put_col    = col_q;
    put_char   = item_char_q;
    put_scroll = 1'b0;
    case (item_char_q)
      CH_NEWLINE: begin
        col_d      = '0;
        row_d      = row_adv;
        put_scroll = (row_q == ROW_LAST);
      end
      CH_RETURN: begin
        col_d = '0;
      end
      CH_BACKSPACE: begin
        if (col_q != '0) begin
          col_d    = col_q - COL_W'(1);
          put_we   = 1'b1;
          put_col  = col_q - COL_W'(1);
          put_char = CH_BLANK;
        end
      end
      default: begin
        put_we = 1'b1;
        if (col_q == COL_LAST) begin
          col_d      = '0;
          row_d      = row_adv;
          put_scroll = (row_q == ROW_LAST);
        end else begin
          col_d = col_q + COL_W'(1);
        end
      end
    endcase
  end

  assign put_addr    = ADDR_W'(row_q) * ROW_STEP + ADDR_W'(put_col);
  assign cursor_addr = ADDR_W'(row_q) * ROW_STEP + ADDR_W'(col_q);
  assign fill_attr   = cmd_i.fill_init ? RESET_ATTR : attr_q;

  // One write port: sweep fill, pending scroll copy, or put.
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = ptr_q;
    mem_wdata = {fill_attr, CH_BLANK};
    if (cmd_i.fill) begin
      mem_we = 1'b1;
    end else if (pend_q) begin
      mem_we    = 1'b1;
      mem_waddr = wptr_q;
      mem_wdata = rdata_q;
    end else if (cmd_i.put && put_we) begin
      mem_we    = 1'b1;
      mem_waddr = put_addr;
      mem_wdata = {attr_q, put_char};
    end
  end

  assign mem_raddr = cmd_i.copy ? ptr_q + ROW_STEP : item_addr_q;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      screen_q[mem_waddr] <= mem_wdata;
    end
    rdata_q <= screen_q[mem_raddr];
  end

  always_ff @(posedge clk_i) begin
    wptr_q <= ptr_q;
    if (cmd_i.accept) begin
      item_cmd_q      <= command_i;
      item_char_q     <= char_code_i;
      item_addr_q     <= in_range ? ADDR_W'(cell_index_i) : '0;
      item_in_range_q <= in_range;
    end
    if (cmd_i.load_out) begin
      out_row_q      <= OUT_ROW_W'(row_q);
      out_col_q      <= OUT_COL_W'(col_q);
      out_pos_q      <= POS_W'(cursor_addr);
      out_data_q     <= (item_cmd_q == CMD_READ && item_in_range_q) ? rdata_q : '0;
      out_scrolled_q <= scrolled_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      attr_q      <= RESET_ATTR;
      row_q       <= '0;
      col_q       <= '0;
      ptr_q       <= '0;
      pend_q      <= 1'b0;
      scrolled_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        attr_q <= cfg_wdata_i;
      end
      if (cmd_i.put) begin
        row_q <= row_d;
        col_q <= col_d;
      end else if (cmd_i.home) begin
        row_q <= '0;
        col_q <= '0;
      end
      if (cmd_i.ptr_clr) begin
        ptr_q <= '0;
      end else if (cmd_i.copy || cmd_i.fill) begin
        ptr_q <= ptr_q + ADDR_W'(1);
      end
      pend_q <= cmd_i.copy;
      if (cmd_i.accept) begin
        scrolled_q <= 1'b0;
      end else if (cmd_i.put && put_scroll) begin
        scrolled_q <= 1'b1;
      end
      if (cmd_i.load_out) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign sts_o.need_scroll = put_scroll;
  assign sts_o.copy_end    = (ptr_q == COPY_LAST);
  assign sts_o.fill_end    = (ptr_q == CELL_LAST);
  assign sts_o.out_free    = !out_valid_q || !out_stall_i;

  assign out_valid_o       = out_valid_q;
  assign cursor_row_o      = out_row_q;
  assign cursor_col_o      = out_col_q;
  assign cursor_position_o = out_pos_q;
  assign cell_data_o       = out_data_q;
  assign scrolled_o        = out_scrolled_q;

endmodule

### design/text_console_writer_core.sv
// ----------------------------------------------------------------------------
// Text console writer core
// Character-cell screen with a cursor: put character, clear and cell read.
// ----------------------------------------------------------------------------
//   Channel  Handshake             Contents
//   input    in_valid_i/in_stall_o command_i, char_code_i, cell_index_i
//   output   out_valid_o/out_stall_i cursor_row_o, cursor_col_o,
//                                  cursor_position_o, cell_data_o, scrolled_o
//   config   cfg_we_i              cfg_wdata_i (text attribute)
//
// A put without scroll or a read goes from IDLE through PUT or READ to DONE, which loads the result.
// Clear and scroll walk the screen store cell by cell through its single write port;
// a scroll copies each row up by one and then blanks the bottom row.
// After reset a clearing pass over all ROWS*COLUMNS cells runs before input is taken.
// The next item is taken while a result waits in the output register; a stalled
// output only holds the controller once the following result is ready.
module text_console_writer_core import tcw_pkg::*; #(
  parameter int COLUMNS = DEF_COLUMNS,
  parameter int ROWS    = DEF_ROWS
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [ATTR_W-1:0]    cfg_wdata_i,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [CMD_W-1:0]     command_i,
  input  logic [CHAR_W-1:0]    char_code_i,
  input  logic [IDX_W-1:0]     cell_index_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [OUT_ROW_W-1:0] cursor_row_o,
  output logic [OUT_COL_W-1:0] cursor_col_o,
  output logic [POS_W-1:0]     cursor_position_o,
  output logic [CELL_W-1:0]    cell_data_o,
  output logic                 scrolled_o
);

  ctrl_cmd_t ctrl_cmd;
  dp_sts_t   dp_sts;

  tcw_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .command_i  (command_i),
    .in_stall_o (in_stall_o),
    .sts_i      (dp_sts),
    .cmd_o      (ctrl_cmd)
  );

  tcw_dp #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_wdata_i       (cfg_wdata_i),
    .command_i         (command_i),
    .char_code_i       (char_code_i),
    .cell_index_i      (cell_index_i),
    .cmd_i             (ctrl_cmd),
    .sts_o             (dp_sts),
    .out_stall_i       (out_stall_i),
    .out_valid_o       (out_valid_o),
    .cursor_row_o      (cursor_row_o),
    .cursor_col_o      (cursor_col_o),
    .cursor_position_o (cursor_position_o),
    .cell_data_o       (cell_data_o),
    .scrolled_o        (scrolled_o)
  );

endmodule

### design/tcw_checker.sv
// ----------------------------------------------------------------------------
// Text console writer checker
// Port-level checks on the result channel, bound to the core.
// ----------------------------------------------------------------------------
`include "text_console_writer_core_defines.svh"

module tcw_checker import tcw_pkg::*; #(
  parameter int COLUMNS = DEF_COLUMNS,
  parameter int ROWS    = DEF_ROWS
) (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 out_valid_i,
  input logic                 out_stall_i,
  input logic [OUT_ROW_W-1:0] cursor_row_i,
  input logic [OUT_COL_W-1:0] cursor_col_i,
  input logic [POS_W-1:0]     cursor_position_i,
  input logic [CELL_W-1:0]    cell_data_i,
  input logic                 scrolled_i
);

  // A stalled result stays offered and unchanged.
  `TCW_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_i && out_stall_i, out_valid_i && $stable(cursor_position_i) && $stable(cell_data_i) && $stable(scrolled_i))

  `TCW_ASSERT_NOW(a_col_range, clk_i, rst_ni, out_valid_i, {25'd0, cursor_col_i} < 32'(COLUMNS))

  `TCW_ASSERT_NOW(a_row_range, clk_i, rst_ni, out_valid_i, {27'd0, cursor_row_i} < 32'(ROWS))

  // A scroll only comes from a newline or a wrap, both ending at column 0 of the last row.
  `TCW_ASSERT_NOW(a_scroll_cursor, clk_i, rst_ni, out_valid_i && scrolled_i, cursor_row_i == OUT_ROW_W'(ROWS - 1) && cursor_col_i == '0)

endmodule

bind text_console_writer_core tcw_checker #(
  .COLUMNS (COLUMNS),
  .ROWS    (ROWS)
) u_tcw_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .out_valid_i       (out_valid_o),
  .out_stall_i       (out_stall_i),
  .cursor_row_i      (cursor_row_o),
  .cursor_col_i      (cursor_col_o),
  .cursor_position_i (cursor_position_o),
  .cell_data_i       (cell_data_o),
  .scrolled_i        (scrolled_o)
);
